/* hdl/sacl_pkg.sv */
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared constants, types and helpers of the set-associative tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package sacl_pkg;

    localparam int SET_BITS   = 4;
    localparam int WAYS       = 4;
    localparam int BLOCK_BITS = 6;
    localparam int ADDR_BITS  = 32;
    localparam int STAMP_BITS = 32;
    localparam int CNT_BITS   = 32;
    localparam int LAT_BITS   = 16;

    localparam int NUM_SETS = 1 << SET_BITS;
    localparam int TAG_BITS = ADDR_BITS - BLOCK_BITS - SET_BITS;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;

    // One way's metadata as held in the line memory
    typedef struct packed {
        logic                  valid;
        logic [TAG_BITS-1:0]   tag;
        logic [STAMP_BITS-1:0] stamp;
        logic [CNT_BITS-1:0]   use_count;
    } line_t;

    localparam int LINE_BITS = $bits(line_t);
    localparam int SET_LINE_BITS = LINE_BITS * WAYS;

    // Result status codes
    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_FILL  = 2'd1;
    localparam logic [1:0] ST_EVICT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_LFU_MODE      = 2'd0;
    localparam logic [1:0] REG_HIT_LATENCY   = 2'd1;
    localparam logic [1:0] REG_MISS_LATENCY  = 2'd2;
    localparam logic [1:0] REG_EVICT_LATENCY = 2'd3;

    localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

    function automatic logic [CNT_BITS-1:0] sat_inc(input logic [CNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* hdl/sacl_if.sv */
// ----------------------------------------------------------------------------
// sacl_req_if / sacl_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sacl_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] addr;
    modport source (output valid, output addr, input ready);
    modport sink   (input valid, input addr, output ready);
endinterface

interface sacl_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] fill_addr;
    logic [31:0] evict_addr;
    logic [15:0] latency;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
    logic [31:0] evict_total;
    modport source (output valid, output status, output fill_addr,
                    output evict_addr, output latency, output hit_total,
                    output miss_total, output evict_total, input ready);
    modport sink   (input valid, input status, input fill_addr,
                    input evict_addr, input latency, input hit_total,
                    input miss_total, input evict_total, output ready);
endinterface

`default_nettype wire

/* hdl/sacl_ram.sv */
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/set_assoc_cache_lfu_lru.sv */
// Latency: the set is read at the accepting edge, compared in the next cycle and
// the result is registered at the end of that cycle.
// Throughput: no new request is taken until the read-modify-write of the set
// memory ends (read at accept, write-back in lookup) or while a result is held.
// Reset: control, totals and valid bits clear at once; no clearing pass.
// ----------------------------------------------------------------------------
// set_assoc_cache_lfu_lru
// Tag store of a set-associative cache with LFU or LRU replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_cache_lfu_lru
    import sacl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    sacl_req_if.sink         req,
    sacl_rsp_if.source       rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;

    logic [1:0] state_reg, state_next;

    logic lfu_mode_reg;
    logic [LAT_BITS-1:0] hit_lat_reg, miss_lat_reg, evict_lat_reg;

    logic [NUM_SETS*WAYS-1:0] valid_reg;
    logic [STAMP_BITS-1:0]    clock_reg [NUM_SETS];

    logic [SET_W-1:0]    set_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic [CNT_BITS-1:0] hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;

    logic                     out_valid_reg;
    logic [1:0]               out_status_reg;
    logic [ADDR_BITS-1:0]     out_ins_reg, out_vic_reg;
    logic [LAT_BITS-1:0]      out_lat_reg;

    logic [SET_LINE_BITS-1:0] rd_data, wr_data;
    logic [SET_W-1:0]         in_set;
    logic                     accept;
    logic                     ram_we;

    line_t lines   [WAYS];
    line_t lines_w [WAYS];

    assign in_set = SET_W'((req.addr >> BLOCK_BITS) & (NUM_SETS - 1));
    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !(out_valid_reg && !rsp.ready);

    sacl_ram #(.WIDTH(SET_LINE_BITS), .DEPTH(NUM_SETS)) u_lines (
        .clk  (clk),
        .we   (ram_we),
        .waddr(set_reg),
        .wdata(wr_data),
        .raddr(in_set),
        .rdata(rd_data)
    );

    // Look up the set read from memory
    logic [STAMP_BITS-1:0] clk1, clk2;
    logic                  hit_found, free_found;
    logic [WAY_BITS-1:0]   hit_way, free_way, vic_way, tgt_way;
    logic [1:0]            status;

    always_comb
    begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        vic_way    = '0;
        clk1 = clock_reg[set_reg] + 1'b1;
        clk2 = clk1 + 1'b1;
        for (int w = 0; w < WAYS; w++)
        begin
            lines[w] = rd_data[w*LINE_BITS +: LINE_BITS];
            lines[w].valid = valid_reg[set_reg*WAYS + w];
        end
        for (int w = 0; w < WAYS; w++)
        begin
            if (lines[w].valid && lines[w].tag == tag_reg && !hit_found)
            begin
                hit_found = 1'b1;
                hit_way   = WAY_BITS'(w);
            end
            if (!lines[w].valid && !free_found)
            begin
                free_found = 1'b1;
                free_way   = WAY_BITS'(w);
            end
        end
        for (int w = 1; w < WAYS; w++)
        begin
            if (lfu_mode_reg)
            begin
                if (lines[w].use_count < lines[vic_way].use_count ||
                    (lines[w].use_count == lines[vic_way].use_count &&
                     lines[w].stamp < lines[vic_way].stamp))
                begin
                    vic_way = WAY_BITS'(w);
                end
            end
            else if (lines[w].stamp < lines[vic_way].stamp)
            begin
                vic_way = WAY_BITS'(w);
            end
        end
        if (hit_found)
        begin
            status  = ST_HIT;
            tgt_way = hit_way;
        end
        else if (free_found)
        begin
            status  = ST_FILL;
            tgt_way = free_way;
        end
        else
        begin
            status  = ST_EVICT;
            tgt_way = vic_way;
        end
        for (int w = 0; w < WAYS; w++)
        begin
            lines_w[w] = lines[w];
        end
        if (status == ST_HIT)
        begin
            if (lfu_mode_reg)
                lines_w[tgt_way].use_count = sat_inc(lines[tgt_way].use_count);
            else
                lines_w[tgt_way].stamp = clk1;
        end
        else
        begin
            lines_w[tgt_way].valid     = 1'b1;
            lines_w[tgt_way].tag       = tag_reg;
            lines_w[tgt_way].stamp     = clk1;
            lines_w[tgt_way].use_count = CNT_BITS'(1);
        end
        for (int w = 0; w < WAYS; w++)
        begin
            wr_data[w*LINE_BITS +: LINE_BITS] = lines_w[w];
        end
    end

    assign ram_we = (state_reg == S_LOOK);

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_LOOK;
            S_LOOK:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfu_mode_reg  <= 1'b1;
            hit_lat_reg   <= LAT_BITS'(1);
            miss_lat_reg  <= LAT_BITS'(100);
            evict_lat_reg <= LAT_BITS'(100);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LFU_MODE:      lfu_mode_reg  <= cfg_wdata[0];
                REG_HIT_LATENCY:   hit_lat_reg   <= cfg_wdata;
                REG_MISS_LATENCY:  miss_lat_reg  <= cfg_wdata;
                REG_EVICT_LATENCY: evict_lat_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Control state, clocks, valid bits and totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            for (int s = 0; s < NUM_SETS; s++)
            begin
                clock_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (rsp.valid && rsp.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_LOOK)
            begin
                out_valid_reg <= 1'b1;
                clock_reg[set_reg] <= clk2;
                valid_reg[set_reg*WAYS + tgt_way] <= 1'b1;
                if (status == ST_HIT)
                    hit_cnt_reg <= sat_inc(hit_cnt_reg);
                else
                    miss_cnt_reg <= sat_inc(miss_cnt_reg);
                if (status == ST_EVICT)
                    evict_cnt_reg <= sat_inc(evict_cnt_reg);
            end
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            set_reg <= in_set;
            tag_reg <= TAG_BITS'(req.addr >> (BLOCK_BITS + SET_BITS));
        end
        if (state_reg == S_LOOK)
        begin
            out_status_reg <= status;
            out_ins_reg <= (status == ST_HIT) ? '0 :
                {tag_reg, set_reg, {BLOCK_BITS{1'b0}}};
            out_vic_reg <= (status == ST_EVICT) ?
                {lines[vic_way].tag, set_reg, {BLOCK_BITS{1'b0}}} : '0;
            case (status)
                ST_HIT:  out_lat_reg <= hit_lat_reg;
                ST_FILL: out_lat_reg <= miss_lat_reg;
                default: out_lat_reg <= evict_lat_reg;
            endcase
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.fill_addr   = out_ins_reg;
    assign rsp.evict_addr  = out_vic_reg;
    assign rsp.latency     = out_lat_reg;
    assign rsp.hit_total   = hit_cnt_reg;
    assign rsp.miss_total  = miss_cnt_reg;
    assign rsp.evict_total = evict_cnt_reg;

endmodule

`default_nettype wire

/* hdl/sacl_checker.sv */
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks of the tag store, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sacl_checker
    import sacl_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    sacl_req_if.sink   req,
    sacl_rsp_if.source rsp
);

    // Result held while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
        else $error("result dropped under stall");

    // An accepted request yields a result after its lookup
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> ##1 rsp.valid)
        else $error("result missing");

    // No back-to-back requests
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken during lookup");

    // A hit carries no block addresses
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_HIT |->
        rsp.fill_addr == '0 && rsp.evict_addr == '0)
        else $error("hit with address");

endmodule

bind set_assoc_cache_lfu_lru sacl_checker u_checker (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
);

`default_nettype wire

/* tb/sv/set_assoc_cache_lfu_lru_tb.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_lfu_lru_tb
// Drives byte addresses into the tag store under both replacement policies and
// several latency settings, predicts hit, fill and eviction per access from a
// behavioral copy of the sets, and checks every result field in order.
// ----------------------------------------------------------------------------
`default_nettype none

class lookup_scoreboard;
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] fill_addr;
        logic [31:0] evict_addr;
        logic [15:0] latency;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] evict_total;
    } lookup_t;

    bit          valid_q [sacl_pkg::NUM_SETS][sacl_pkg::WAYS];
    bit [21:0]   tag_q   [sacl_pkg::NUM_SETS][sacl_pkg::WAYS];
    bit [31:0]   stamp_q [sacl_pkg::NUM_SETS][sacl_pkg::WAYS];
    bit [31:0]   uses_q  [sacl_pkg::NUM_SETS][sacl_pkg::WAYS];
    bit [31:0]   clock_q [sacl_pkg::NUM_SETS];
    bit [31:0]   hits, misses, evicts;
    bit          lfu;
    bit [15:0]   lat_hit, lat_miss, lat_evict;
    lookup_t     pending [$];
    int          errors;

    function new();
        lfu = 1'b1; lat_hit = 16'd1; lat_miss = 16'd100; lat_evict = 16'd100;
        hits = 0; misses = 0; evicts = 0; errors = 0;
        foreach (valid_q[s, w])
        begin
            valid_q[s][w] = 1'b0; stamp_q[s][w] = 0; uses_q[s][w] = 0; tag_q[s][w] = '0;
        end
        foreach (clock_q[s]) clock_q[s] = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            sacl_pkg::REG_LFU_MODE:      lfu = val[0];
            sacl_pkg::REG_HIT_LATENCY:   lat_hit = val;
            sacl_pkg::REG_MISS_LATENCY:  lat_miss = val;
            sacl_pkg::REG_EVICT_LATENCY: lat_evict = val;
        endcase
    endfunction

    function bit [31:0] bump(bit [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    // Predict the lookup result of one accepted address
    function void note_request(logic [31:0] addr);
        lookup_t r;
        int set, hw, fw, v;
        bit [21:0] tag;
        set = int'(addr[9:6]);
        tag = addr[31:10];
        hw = -1; fw = -1;
        r = '0;
        clock_q[set]++;
        for (int w = 0; w < sacl_pkg::WAYS; w++)
        begin
            if (valid_q[set][w] && tag_q[set][w] == tag && hw < 0) hw = w;
            if (!valid_q[set][w] && fw < 0) fw = w;
        end
        if (hw >= 0)
        begin
            if (lfu) uses_q[set][hw] = bump(uses_q[set][hw]);
            else stamp_q[set][hw] = clock_q[set];
            clock_q[set]++;
            hits = bump(hits);
            r.status = sacl_pkg::ST_HIT;
            r.latency = lat_hit;
        end
        else
        begin
            if (fw >= 0)
            begin
                v = fw;
                r.status = sacl_pkg::ST_FILL;
                r.latency = lat_miss;
            end
            else
            begin
                v = 0;
                for (int w = 1; w < sacl_pkg::WAYS; w++)
                    if (lfu ? (uses_q[set][w] < uses_q[set][v] ||
                               (uses_q[set][w] == uses_q[set][v] &&
                                stamp_q[set][w] < stamp_q[set][v]))
                            : stamp_q[set][w] < stamp_q[set][v])
                        v = w;
                r.evict_addr = {tag_q[set][v], set[3:0], 6'd0};
                r.status = sacl_pkg::ST_EVICT;
                r.latency = lat_evict;
                evicts = bump(evicts);
            end
            valid_q[set][v] = 1'b1;
            tag_q[set][v] = tag;
            stamp_q[set][v] = clock_q[set];
            uses_q[set][v] = 1;
            clock_q[set]++;
            misses = bump(misses);
            r.fill_addr = {addr[31:6], 6'd0};
        end
        r.hit_total = hits; r.miss_total = misses; r.evict_total = evicts;
        pending.push_back(r);
    endfunction

    // Compare one result with the oldest prediction
    function void check_result(lookup_t got);
        lookup_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result status=%0d", got.status);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.status != e.status)
        begin $error("status exp %0d got %0d", e.status, got.status); errors++; end
        if (got.fill_addr != e.fill_addr)
        begin
            $error("fill_addr exp %h got %h", e.fill_addr, got.fill_addr);
            errors++;
        end
        if (got.evict_addr != e.evict_addr)
        begin
            $error("evict_addr exp %h got %h", e.evict_addr, got.evict_addr);
            errors++;
        end
        if (got.latency != e.latency)
        begin $error("latency exp %0d got %0d", e.latency, got.latency); errors++; end
        if (got.hit_total != e.hit_total)
        begin $error("hit_total exp %0d got %0d", e.hit_total, got.hit_total); errors++; end
        if (got.miss_total != e.miss_total)
        begin $error("miss_total exp %0d got %0d", e.miss_total, got.miss_total); errors++; end
        if (got.evict_total != e.evict_total)
        begin
            $error("evict_total exp %0d got %0d", e.evict_total, got.evict_total);
            errors++;
        end
    endfunction
endclass

module set_assoc_cache_lfu_lru_tb;
    import sacl_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;

    sacl_req_if req ();
    sacl_rsp_if rsp ();

    lookup_scoreboard tags;
    logic [31:0]      tag_pool [8];

    set_assoc_cache_lfu_lru dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    initial clk = 0;
    always #6 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("set_assoc_cache_lfu_lru: mismatch");
        $finish;
    end

    // Hold the result ready low for a random gap before each result
    initial
    begin
        int gap;
        rsp.ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = $urandom_range(0, 4);
            rsp.ready = 0;
            repeat (gap) @(negedge clk);
            rsp.ready = 1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    // Check each accepted result
    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            tags.check_result({rsp.status, rsp.fill_addr, rsp.evict_addr,
                               rsp.latency, rsp.hit_total, rsp.miss_total,
                               rsp.evict_total});

    task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we = 1; cfg_index = idx; cfg_wdata = val;
        @(negedge clk);
        cfg_we = 0;
        tags.write_reg(idx, val);
    endtask

    task automatic send_request(logic [31:0] addr, bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        repeat (gap) @(negedge clk);
        req.valid = 1; req.addr = addr;
        do @(posedge clk); while (!req.ready);
        tags.note_request(addr);
        @(negedge clk);
        req.valid = 0;
    endtask

    task automatic drain();
        while (tags.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Mostly addresses from a few tags per set, so sets fill and evict often
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        if ($urandom_range(0, 9) == 0) return $urandom;
        a = tag_pool[$urandom_range(0, 7)];
        a[9:6] = 4'($urandom_range(0, 3));
        a[5:0] = 6'($urandom);
        return a;
    endfunction

    initial
    begin
        tags = new();
        rst_n = 0; cfg_we = 0; cfg_index = REG_LFU_MODE; cfg_wdata = 0;
        req.valid = 0; req.addr = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: extremes, fills, hits, then eviction in LFU mode
        send_request(32'h0000_0000);
        send_request(32'hFFFF_FFFF);
        send_request(32'h0000_003F);
        for (int k = 1; k <= 4; k++) send_request({22'(k), 4'd0, 6'd0});
        send_request({22'd2, 4'd0, 6'd5});
        send_request({22'd9, 4'd0, 6'd0});
        send_request(32'hAAAA_AAAA);
        send_request(32'h5555_5555);
        drain();

        // Directed: LRU policy with extreme latencies
        write_cfg(REG_LFU_MODE, 16'd0);
        write_cfg(REG_HIT_LATENCY, 16'hFFFF);
        write_cfg(REG_MISS_LATENCY, 16'd0);
        write_cfg(REG_EVICT_LATENCY, 16'hFFFF);
        for (int k = 1; k <= 4; k++) send_request({22'(k + 16), 4'd1, 6'd0}, 1);
        send_request({22'd17, 4'd1, 6'd0});
        send_request({22'd30, 4'd1, 6'd0});
        send_request({22'd31, 4'd1, 6'd0});
        drain();

        // Random phases over several register settings
        for (int phase = 0; phase < 4; phase++)
        begin
            write_cfg(REG_LFU_MODE, 16'(phase % 2 == 0));
            write_cfg(REG_HIT_LATENCY, phase == 3 ? 16'd0 : 16'($urandom));
            write_cfg(REG_MISS_LATENCY, phase == 3 ? 16'hFFFF : 16'($urandom));
            write_cfg(REG_EVICT_LATENCY, phase == 3 ? 16'd0 : 16'($urandom));
            foreach (tag_pool[i]) tag_pool[i] = $urandom;
            for (int n = 0; n < 95; n++)
            begin
                send_request(pick_addr(), n % 20 < 5);
                if (n == 50) drain();
            end
            drain();
        end

        if (tags.errors == 0 && tags.pending.size() == 0)
            $display("set_assoc_cache_lfu_lru: match");
        else
            $display("set_assoc_cache_lfu_lru: mismatch");
        $finish;
    end
endmodule

`default_nettype wire
